/* sv/sha1_pkg.sv */
// Shared types, constants and widths for the SHA-1 byte stream hasher.
// Used by sha1_sched, sha1_round and sha1_byte_stream_hasher_core.
package sha1_pkg;

    localparam int RoundCount = 80;
    localparam int RND_W      = $clog2(RoundCount);
    localparam int LEN_W      = 61;
    localparam int BITS_W     = 64;
    localparam int FILL_W     = 6;
    localparam int BLOCK_W    = 512;

    localparam logic [31:0] K_00_19 = 32'h5a827999;
    localparam logic [31:0] K_20_39 = 32'h6ed9eba1;
    localparam logic [31:0] K_40_59 = 32'h8f1bbcdc;
    localparam logic [31:0] K_60_79 = 32'hca62c1d6;

    localparam logic [7:0]        PAD_MARK  = 8'h80;
    localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
    localparam logic [FILL_W-1:0] FILL_LEN  = 6'd56;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha1_vars_t;

    localparam sha1_vars_t H_INIT = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476,
        e: 32'hc3d2e1f0
    };

    typedef struct packed {
        logic       load;
        logic       shift;
        logic [7:0] data;
    } sha1_sched_ctl_t;

endpackage

/* sv/sha1_sched.sv */
// Block buffer and message schedule window: bytes shift in, words shift out.
// Depends on sha1_pkg.
module sha1_sched
    import sha1_pkg::*;
(
    input  logic            aclk,
    input  sha1_sched_ctl_t ctl,
    output logic [31:0]     w_cur
);

    logic [BLOCK_W-1:0] blk_reg;
    logic [BLOCK_W-1:0] blk_next;
    logic [31:0]        w_mix;
    logic [31:0]        w_new;

    // Top word is w[t]; w[t+2], w[t+8], w[t+13] sit at words 13, 7 and 2.
    assign w_cur = blk_reg[BLOCK_W-1 -: 32];
    assign w_mix = blk_reg[15*32 +: 32] ^ blk_reg[13*32 +: 32] ^
                   blk_reg[7*32 +: 32] ^ blk_reg[2*32 +: 32];
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb begin
        blk_next = blk_reg;
        if (ctl.load) begin
            blk_next = {blk_reg[BLOCK_W-9:0], ctl.data};
        end else if (ctl.shift) begin
            blk_next = {blk_reg[BLOCK_W-33:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
    end

endmodule

/* sv/sha1_round.sv */
// One SHA-1 compression round, shared over all 80 rounds of a block.
// Depends on sha1_pkg.
module sha1_round
    import sha1_pkg::*;
(
    input  sha1_vars_t       cur,
    input  logic [31:0]      w,
    input  logic [RND_W-1:0] rnd,
    output sha1_vars_t       nxt
);

    logic [31:0] f;
    logic [31:0] k;

    always_comb begin
        if (rnd < RND_W'(20)) begin
            f = (cur.b & cur.c) | (~cur.b & cur.d);
            k = K_00_19;
        end else if (rnd < RND_W'(40)) begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_20_39;
        end else if (rnd < RND_W'(60)) begin
            f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k = K_40_59;
        end else begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_60_79;
        end
    end

    always_comb begin
        nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + w + k;
        nxt.b = cur.a;
        nxt.c = {cur.b[1:0], cur.b[31:2]};
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

/* sv/sha1_byte_stream_hasher_core.sv */
// Streaming SHA-1 hasher top level: sequencer, chaining words, length and output register.
// Depends on sha1_pkg, sha1_sched and sha1_round.
//
// A message byte (tuser 0) is taken whenever s_tready is high. The byte that fills a 64-byte
// block starts the compression, which runs the single round unit once per cycle through the
// 80 rounds and then adds into the chaining words; no bytes are taken until it is done. A
// finish transfer (tuser 1) pushes the 0x80 marker, then zeros and the 8 length bytes one per
// cycle through the same buffer, compresses one or two blocks, and then loads the digest into
// the output register; the hasher is ready again for a new message in the cycle after that.
// The result stays on m_tdata until taken, and bytes of the next message are accepted while
// it waits.
module sha1_byte_stream_hasher_core
    import sha1_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_tuser,   // [0] mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata    // digest_word0 .. digest_word4, 32 bits each
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FINAL,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    sha1_vars_t        chain_reg, chain_next;
    sha1_vars_t        vars_reg, vars_next;
    sha1_vars_t        dout_reg, dout_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic              pad_reg, pad_next;
    logic              len_phase_reg, len_phase_next;

    sha1_sched_ctl_t   sched_ctl;
    logic [31:0]       w_cur;
    sha1_vars_t        round_out;
    logic              is_len;
    logic [2:0]        len_sel;

    sha1_sched u_sched (
        .aclk  (aclk),
        .ctl   (sched_ctl),
        .w_cur (w_cur)
    );

    sha1_round u_round (
        .cur (vars_reg),
        .w   (w_cur),
        .rnd (rnd_reg),
        .nxt (round_out)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {dout_reg.e, dout_reg.d, dout_reg.c, dout_reg.b, dout_reg.a};

    assign is_len  = len_phase_reg || (fill_reg == FILL_LEN);
    assign len_sel = 3'd7 - fill_reg[2:0];

    always_comb begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        vars_next      = vars_reg;
        dout_next      = dout_reg;
        m_tvalid_next  = m_tvalid_reg;
        rnd_next       = rnd_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        bits_next      = bits_reg;
        pad_next       = pad_reg;
        len_phase_next = len_phase_reg;
        sched_ctl      = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    sched_ctl.load = 1'b1;
                    fill_next      = fill_reg + 1'b1;
                    if (s_tuser[0] == 1'b0) begin
                        sched_ctl.data = s_tdata;
                        len_next       = len_reg + 1'b1;
                    end else begin
                        sched_ctl.data = PAD_MARK;
                        pad_next       = 1'b1;
                        bits_next      = {len_reg, 3'b000};
                        state_next     = S_PAD;
                    end
                    if (fill_reg == FILL_LAST) begin
                        vars_next  = chain_reg;
                        rnd_next   = '0;
                        state_next = S_ROUND;
                    end
                end
            end
            S_PAD: begin
                sched_ctl.load = 1'b1;
                sched_ctl.data = is_len ? bits_reg[{len_sel, 3'b000} +: 8] : 8'h00;
                len_phase_next = is_len;
                fill_next      = fill_reg + 1'b1;
                if (fill_reg == FILL_LAST) begin
                    vars_next  = chain_reg;
                    rnd_next   = '0;
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                sched_ctl.shift = 1'b1;
                vars_next       = round_out;
                rnd_next        = rnd_reg + 1'b1;
                if (rnd_reg == RND_W'(RoundCount - 1)) begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL: begin
                chain_next.a = chain_reg.a + vars_reg.a;
                chain_next.b = chain_reg.b + vars_reg.b;
                chain_next.c = chain_reg.c + vars_reg.c;
                chain_next.d = chain_reg.d + vars_reg.d;
                chain_next.e = chain_reg.e + vars_reg.e;
                if (!pad_reg) begin
                    state_next = S_IDLE;
                end else if (len_phase_reg) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_PAD;
                end
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    dout_next      = chain_reg;
                    m_tvalid_next  = 1'b1;
                    chain_next     = H_INIT;
                    len_next       = '0;
                    fill_next      = '0;
                    pad_next       = 1'b0;
                    len_phase_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            chain_reg     <= H_INIT;
            m_tvalid_reg  <= 1'b0;
            rnd_reg       <= '0;
            fill_reg      <= '0;
            len_reg       <= '0;
            pad_reg       <= 1'b0;
            len_phase_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            m_tvalid_reg  <= m_tvalid_next;
            rnd_reg       <= rnd_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            pad_reg       <= pad_next;
            len_phase_reg <= len_phase_next;
        end
        vars_reg <= vars_next;
        dout_reg <= dout_next;
        bits_reg <= bits_next;
    end

`ifndef SYNTHESIS
    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ROUND |-> rnd_reg < RND_W'(RoundCount))
        else $error("round index out of range");

    a_block_boundary: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ROUND && rnd_reg == RND_W'(RoundCount - 1) |=> fill_reg == '0)
        else $error("compression finished with a partial block");

    a_len_phase_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        len_phase_reg |-> pad_reg)
        else $error("length bytes outside of padding");

    a_emit_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT && (!m_tvalid_reg || m_tready)
        |=> m_tvalid_reg && chain_reg == H_INIT && len_reg == '0 && !pad_reg)
        else $error("state not restored after digest");
`endif

endmodule
